// ===== hw/rtl/qvmr_pkg.sv =====
// qvmr_pkg: shared types, codes and constants of the quad vertex move/rotate block
// no dependencies; imported by every module of the block
package qvmr_pkg;

    // input mode codes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_MOVE   = 2'd1;
    localparam logic [1:0] MODE_ROTATE = 2'd2;

    // angle arithmetic
    localparam int FULL_TURN    = 92160;
    localparam int QUARTER_TURN = 23040;
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [14:0] DIV_BIAS = 15'd23040;
    // pi*2^30 split as a whole multiple of 46080 plus a remainder
    localparam logic [16:0] RAD_QUOT = 17'(PI_Q30 / 32'd46080);
    localparam logic [14:0] RAD_REM  = 15'(PI_Q30 % 32'd46080);
    localparam int RAD_PRE_SHIFT = 10;
    // floor(k / 45) as (k * RECIP_45) >> RECIP_SHIFT, exact for k below 2^19
    localparam logic [19:0] RECIP_45 = 20'd745655;
    localparam int RECIP_SHIFT = 25;
    localparam int CORDIC_STEPS = 30;
    localparam int CS_W = 33;
    localparam int CORDIC_W = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_INIT = 34'sh026DD3B6A;
    localparam logic signed [CORDIC_W-1:0] ONE_Q30 = 34'sh040000000;

    // command queue depth
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {OP_LOAD, OP_MOVE, OP_ROTATE} op_t;

    typedef struct packed {
        op_t                op;
        logic [1:0]         sel;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [1:0]         quad;
        logic [14:0]        rem;
    } cmd_t;

    typedef struct packed {
        logic                  done;
        logic signed [CS_W-1:0] cos_v;
        logic signed [CS_W-1:0] sin_v;
    } trig_res_t;

    typedef enum logic [1:0] {TR_IDLE, TR_DIV, TR_ROT, TR_DONE} trig_state_t;

    typedef enum logic [2:0] {BK_IDLE, BK_TRIG, BK_MOVE, BK_PREP, BK_MUL, BK_WB} back_state_t;

    // arctangent table in Q2.30, truncated
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  return 32'h3243F6A8;
            5'd1:  return 32'h1DAC6705;
            5'd2:  return 32'h0FADBAFC;
            5'd3:  return 32'h07F56EA6;
            5'd4:  return 32'h03FEAB76;
            5'd5:  return 32'h01FFD55B;
            5'd6:  return 32'h00FFFAAA;
            5'd7:  return 32'h007FFF55;
            5'd8:  return 32'h003FFFEA;
            5'd9:  return 32'h001FFFFD;
            5'd10: return 32'h000FFFFF;
            5'd11: return 32'h0007FFFF;
            5'd12: return 32'h0003FFFF;
            5'd13: return 32'h0001FFFF;
            5'd14: return 32'h0000FFFF;
            5'd15: return 32'h00007FFF;
            5'd16: return 32'h00003FFF;
            5'd17: return 32'h00001FFF;
            5'd18: return 32'h00000FFF;
            5'd19: return 32'h000007FF;
            5'd20: return 32'h000003FF;
            5'd21: return 32'h000001FF;
            5'd22: return 32'h000000FF;
            5'd23: return 32'h0000007F;
            5'd24: return 32'h0000003F;
            5'd25: return 32'h0000001F;
            5'd26: return 32'h0000000F;
            5'd27: return 32'h00000008;
            5'd28: return 32'h00000004;
            5'd29: return 32'h00000002;
            default: return 32'h00000000;
        endcase
    endfunction

endpackage

// ===== hw/rtl/qvmr_front.sv =====
// qvmr_front: takes command words, drops the ones that do nothing, reduces the angle
// depends on qvmr_pkg
module qvmr_front #(
    parameter int VERTEX_COUNT = 4
) (
    input  logic               start,
    input  logic               full,
    input  logic [1:0]         mode,
    input  logic [1:0]         vertex_sel,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] shift_x,
    input  logic signed [31:0] shift_y,
    input  logic signed [17:0] turn_angle,
    output logic               push,
    output qvmr_pkg::cmd_t     cmd
);
    import qvmr_pkg::*;

    localparam logic signed [18:0] FULL19 = 19'(FULL_TURN);
    localparam logic [16:0] Q1 = 17'(QUARTER_TURN);
    localparam logic [16:0] Q2 = 17'(2 * QUARTER_TURN);
    localparam logic [16:0] Q3 = 17'(3 * QUARTER_TURN);

    logic signed [18:0] t1;
    logic signed [18:0] t2;
    logic signed [18:0] t3;
    logic [16:0] a_red;
    logic [1:0]  quad;
    logic [16:0] base;
    logic        useful;

    // angle into one turn, then quadrant and remainder
    always_comb
    begin
        t1 = 19'(turn_angle);
        if (t1 < 0)
            t1 = t1 + FULL19;
        t2 = t1;
        if (t2 < 0)
            t2 = t2 + FULL19;
        t3 = t2;
        if (t3 >= FULL19)
            t3 = t3 - FULL19;
        a_red = t3[16:0];
        if (a_red >= Q3)
        begin
            quad = 2'd3;
            base = Q3;
        end
        else if (a_red >= Q2)
        begin
            quad = 2'd2;
            base = Q2;
        end
        else if (a_red >= Q1)
        begin
            quad = 2'd1;
            base = Q1;
        end
        else
        begin
            quad = 2'd0;
            base = 17'd0;
        end
    end

    // classify the word and build the command
    always_comb
    begin
        cmd.sel  = vertex_sel;
        cmd.quad = quad;
        cmd.rem  = 15'(a_red - base);
        cmd.px   = point_x;
        cmd.py   = point_y;
        case (mode)
            MODE_LOAD:
            begin
                cmd.op = OP_LOAD;
                useful = (32'(vertex_sel) < 32'(VERTEX_COUNT));
            end
            MODE_MOVE:
            begin
                cmd.op = OP_MOVE;
                cmd.px = shift_x;
                cmd.py = shift_y;
                useful = 1'b1;
            end
            MODE_ROTATE:
            begin
                cmd.op = OP_ROTATE;
                useful = 1'b1;
            end
            default:
            begin
                cmd.op = OP_LOAD;
                useful = 1'b0;
            end
        endcase
    end

    assign push = start && !full && useful;

endmodule

// ===== hw/rtl/qvmr_queue.sv =====
// qvmr_queue: short command queue between front and back
// depends on qvmr_pkg
module qvmr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  qvmr_pkg::cmd_t cmd_in,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output qvmr_pkg::cmd_t cmd_out
);
    import qvmr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign cmd_out = slot_reg[rd_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= cmd_in;
    end

endmodule

// ===== hw/rtl/qvmr_trig.sv =====
// qvmr_trig: sine and cosine of a quadrant plus remainder angle
// radian scaling by a reciprocal multiply, then a 30-step cordic; depends on qvmr_pkg
module qvmr_trig (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           quad,
    input  logic [14:0]          rem,
    output qvmr_pkg::trig_res_t  res
);
    import qvmr_pkg::*;

    localparam int BASE_W = 32;
    localparam int MREM_W = 29;
    localparam int K_W    = MREM_W - RAD_PRE_SHIFT;
    localparam int RP_W   = K_W + 20;

    trig_state_t st_reg;
    trig_state_t st_next;
    logic [BASE_W-1:0]           base_reg;
    logic [MREM_W-1:0]           m_reg;
    logic [5:0]                  cnt_reg;
    logic [1:0]                  quad_reg;
    logic signed [CORDIC_W-1:0]  x_reg;
    logic signed [CORDIC_W-1:0]  y_reg;
    logic signed [CORDIC_W-1:0]  z_reg;
    logic [K_W-1:0]              k_val;
    logic [RP_W-1:0]             recip_prod;
    logic signed [CORDIC_W-1:0]  z_init;
    logic signed [CORDIC_W-1:0]  xs;
    logic signed [CORDIC_W-1:0]  ys;
    logic signed [CORDIC_W-1:0]  at;

    // whole part plus the remainder part divided by 1024 then by 45
    always_comb
    begin
        k_val      = m_reg[MREM_W-1:RAD_PRE_SHIFT];
        recip_prod = RP_W'(k_val) * RP_W'(RECIP_45);
        z_init     = signed'(CORDIC_W'(base_reg) +
                             CORDIC_W'(recip_prod[RP_W-1:RECIP_SHIFT]));
    end

    // cordic step terms
    always_comb
    begin
        xs = x_reg >>> cnt_reg[4:0];
        ys = y_reg >>> cnt_reg[4:0];
        at = signed'(CORDIC_W'(atan_q30(cnt_reg[4:0])));
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            TR_IDLE:
                if (start)
                    st_next = (rem == '0) ? TR_DONE : TR_DIV;
            TR_DIV:
                st_next = TR_ROT;
            TR_ROT:
                if (cnt_reg == 6'(CORDIC_STEPS - 1))
                    st_next = TR_DONE;
            TR_DONE:
                st_next = TR_IDLE;
            default:
                st_next = TR_IDLE;
        endcase
    end

    // outputs: quadrant map of the final vector
    always_comb
    begin
        res.done = (st_reg == TR_DONE);
        case (quad_reg)
            2'd1:
            begin
                res.cos_v = CS_W'(-y_reg);
                res.sin_v = CS_W'(x_reg);
            end
            2'd2:
            begin
                res.cos_v = CS_W'(-x_reg);
                res.sin_v = CS_W'(-y_reg);
            end
            2'd3:
            begin
                res.cos_v = CS_W'(y_reg);
                res.sin_v = CS_W'(-x_reg);
            end
            default:
            begin
                res.cos_v = CS_W'(x_reg);
                res.sin_v = CS_W'(y_reg);
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= TR_IDLE;
        else
            st_reg <= st_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (st_reg)
            TR_IDLE:
                if (start)
                begin
                    quad_reg <= quad;
                    base_reg <= BASE_W'(rem) * BASE_W'(RAD_QUOT);
                    m_reg    <= MREM_W'(rem) * MREM_W'(RAD_REM) + MREM_W'(DIV_BIAS);
                    cnt_reg  <= '0;
                    x_reg    <= ONE_Q30;
                    y_reg    <= '0;
                end
            TR_DIV:
            begin
                cnt_reg <= '0;
                x_reg   <= CORDIC_INIT;
                y_reg   <= '0;
                z_reg   <= z_init;
            end
            TR_ROT:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!z_reg[CORDIC_W-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/qvmr_back.sv =====
// qvmr_back: vertex store and the move/rotate sequencer with one shared multiplier
// depends on qvmr_pkg and qvmr_trig results
module qvmr_back #(
    parameter int VERTEX_COUNT = 4,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  qvmr_pkg::cmd_t      cmd,
    output logic                pop,
    output logic                trig_start,
    input  qvmr_pkg::trig_res_t trig,
    output logic                result_strobe,
    output logic [1:0]          vertex_index,
    output logic signed [31:0]  new_x,
    output logic signed [31:0]  new_y,
    output logic                last
);
    import qvmr_pkg::*;

    localparam int IDX_W  = $clog2(VERTEX_COUNT);
    localparam int SUM_W  = COORD_WIDTH + 1;
    localparam int DW     = COORD_WIDTH + 3;
    localparam int LOW_W  = DW / 2;
    localparam int MULA_W = DW - LOW_W + 1;
    localparam int PW     = MULA_W + CS_W;
    localparam int ACC_W  = DW + CS_W + 2;
    localparam int RW     = ACC_W - 31;
    localparam int SAT_W  = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 8;
    localparam logic signed [SAT_W-1:0] SAT_MAX =
        signed'((SAT_W'(1) << (COORD_WIDTH - 1)) - SAT_W'(1));
    localparam logic signed [SAT_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [ACC_W-1:0] HALF_ACC = signed'(ACC_W'(1) << 30);

    back_state_t st_reg;
    back_state_t st_next;

    logic signed [COORD_WIDTH-1:0] vx_reg [VERTEX_COUNT];
    logic signed [COORD_WIDTH-1:0] vy_reg [VERTEX_COUNT];
    logic [IDX_W-1:0]              idx_reg;
    logic [3:0]                    step_reg;
    logic signed [31:0]            dx_reg;
    logic signed [31:0]            dy_reg;
    logic signed [SUM_W-1:0]       sx_reg;
    logic signed [SUM_W-1:0]       sy_reg;
    logic signed [CS_W-1:0]        cs_reg;
    logic signed [CS_W-1:0]        sn_reg;
    logic signed [DW-1:0]          d_reg;
    logic signed [DW-1:0]          e_reg;
    logic signed [PW-1:0]          prod_reg;
    logic                          pend_reg;
    logic [2:0]                    pend_code_reg;
    logic signed [ACC_W-1:0]       accx_reg;
    logic signed [ACC_W-1:0]       accy_reg;
    logic                          strobe_reg;
    logic [1:0]                    index_reg;
    logic signed [31:0]            nx_reg;
    logic signed [31:0]            ny_reg;
    logic                          last_reg;

    logic                          is_last;
    logic                          emit;
    logic signed [COORD_WIDTH-1:0] cur_x;
    logic signed [COORD_WIDTH-1:0] cur_y;
    logic signed [COORD_WIDTH-1:0] res_x;
    logic signed [COORD_WIDTH-1:0] res_y;
    logic signed [DW-1:0]          op_full;
    logic signed [MULA_W-1:0]      op_a;
    logic signed [CS_W-1:0]        op_b;
    logic signed [PW-1:0]          prod_c;
    logic signed [ACC_W-1:0]       term;
    logic signed [ACC_W-1:0]       tx;
    logic signed [ACC_W-1:0]       ty;
    logic [IDX_W-1:0]              load_idx;

    function automatic logic signed [COORD_WIDTH-1:0] sat_cw(input logic signed [SAT_W-1:0] v);
        if (v > SAT_MAX)
            return SAT_MAX[COORD_WIDTH-1:0];
        if (v < SAT_MIN)
            return SAT_MIN[COORD_WIDTH-1:0];
        return v[COORD_WIDTH-1:0];
    endfunction

    assign cur_x    = vx_reg[idx_reg];
    assign cur_y    = vy_reg[idx_reg];
    assign is_last  = (idx_reg == IDX_W'(VERTEX_COUNT - 1));
    assign load_idx = IDX_W'(cmd.sel);

    // operand select and split for the shared multiplier
    always_comb
    begin
        op_full = step_reg[1] ? e_reg : d_reg;
        op_b    = (step_reg[2] ^ step_reg[1]) ? sn_reg : cs_reg;
        if (step_reg[0])
            op_a = MULA_W'(op_full >>> LOW_W);
        else
            op_a = MULA_W'(signed'({1'b0, op_full[LOW_W-1:0]}));
        prod_c = op_a * op_b;
    end

    // partial product aligned for accumulation
    always_comb
    begin
        term = ACC_W'(prod_reg);
        if (pend_code_reg[0])
            term = term <<< LOW_W;
    end

    // centre plus rotated offset, rounded half up, then clamped; on a move, vertex plus shift, clamped
    always_comb
    begin
        tx = (ACC_W'(sx_reg) <<< 30) + accx_reg + HALF_ACC;
        ty = (ACC_W'(sy_reg) <<< 30) + accy_reg + HALF_ACC;
        if (st_reg == BK_MOVE)
        begin
            res_x = sat_cw(SAT_W'(cur_x) + SAT_W'(dx_reg));
            res_y = sat_cw(SAT_W'(cur_y) + SAT_W'(dy_reg));
        end
        else
        begin
            res_x = sat_cw(SAT_W'(signed'(tx[ACC_W-1:31])));
            res_y = sat_cw(SAT_W'(signed'(ty[ACC_W-1:31])));
        end
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE:
                if (q_valid)
                begin
                    case (cmd.op)
                        OP_MOVE:   st_next = BK_MOVE;
                        OP_ROTATE: st_next = BK_TRIG;
                        default:   st_next = BK_IDLE;
                    endcase
                end
            BK_TRIG:
                if (trig.done)
                    st_next = BK_PREP;
            BK_MOVE:
                if (is_last)
                    st_next = BK_IDLE;
            BK_PREP:
                st_next = BK_MUL;
            BK_MUL:
                if (step_reg == 4'd8)
                    st_next = BK_WB;
            BK_WB:
                st_next = is_last ? BK_IDLE : BK_PREP;
            default:
                st_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop        = (st_reg == BK_IDLE) && q_valid;
        trig_start = pop && (cmd.op == OP_ROTATE);
        emit       = (st_reg == BK_MOVE) || (st_reg == BK_WB);
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= BK_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            strobe_reg <= emit;
        end
    end

    // vertex store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VERTEX_COUNT; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
            end
        end
        else if (pop && cmd.op == OP_LOAD)
        begin
            vx_reg[load_idx] <= sat_cw(SAT_W'(cmd.px));
            vy_reg[load_idx] <= sat_cw(SAT_W'(cmd.py));
        end
        else if (emit)
        begin
            vx_reg[idx_reg] <= res_x;
            vy_reg[idx_reg] <= res_y;
        end
    end

    // sequencer datapath
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            index_reg <= idx_reg[1:0];
            nx_reg    <= 32'(res_x);
            ny_reg    <= 32'(res_y);
            last_reg  <= is_last;
            idx_reg   <= is_last ? '0 : idx_reg + 1'b1;
        end
        case (st_reg)
            BK_IDLE:
            begin
                idx_reg <= '0;
                dx_reg  <= cmd.px;
                dy_reg  <= cmd.py;
                sx_reg  <= SUM_W'(vx_reg[0]) + SUM_W'(vx_reg[2]);
                sy_reg  <= SUM_W'(vy_reg[0]) + SUM_W'(vy_reg[2]);
            end
            BK_TRIG:
            begin
                cs_reg <= trig.cos_v;
                sn_reg <= trig.sin_v;
            end
            BK_PREP:
            begin
                d_reg    <= (DW'(cur_x) <<< 1) - DW'(sx_reg);
                e_reg    <= (DW'(cur_y) <<< 1) - DW'(sy_reg);
                accx_reg <= '0;
                accy_reg <= '0;
                step_reg <= '0;
                pend_reg <= 1'b0;
            end
            BK_MUL:
            begin
                step_reg      <= step_reg + 1'b1;
                prod_reg      <= prod_c;
                pend_reg      <= !step_reg[3];
                pend_code_reg <= step_reg[2:0];
                if (pend_reg)
                begin
                    if (pend_code_reg[2])
                        accy_reg <= accy_reg + term;
                    else if (pend_code_reg[1])
                        accx_reg <= accx_reg - term;
                    else
                        accx_reg <= accx_reg + term;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result_strobe = strobe_reg;
    assign vertex_index  = index_reg;
    assign new_x         = nx_reg;
    assign new_y         = ny_reg;
    assign last          = last_reg;

endmodule

// ===== hw/rtl/quad_vertex_move_rotate_top.sv =====
// quad_vertex_move_rotate_top: four-vertex shape store with move and rotate about a centre
// depends on qvmr_pkg, qvmr_front, qvmr_queue, qvmr_trig, qvmr_back
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------------
//  command   | start / busy           | mode, vertex_sel, point_x/y, shift_x/y, turn_angle
//  result    | result_strobe (1 cyc)  | vertex_index, new_x, new_y, last
//
// a word is taken when start is high and busy is low; busy rises while the two-entry
// command queue is full. load: one vertex store write. move: one result per cycle.
// rotate: the trig unit runs a reciprocal-multiply step, 30 cordic steps (none for a zero
// remainder) and a done state; each vertex then takes a prep step, 8 partial products on
// the shared multiplier and a write-back. results are registered and shown for one cycle;
// the receiver cannot stall. reset clears the vertex store to zero and empties the queue.
module quad_vertex_move_rotate_top #(
    parameter int VERTEX_COUNT = 4,
    parameter int COORD_WIDTH  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [1:0]         vertex_sel,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] shift_x,
    input  logic signed [31:0] shift_y,
    input  logic signed [17:0] turn_angle,
    output logic               result_strobe,
    output logic [1:0]         vertex_index,
    output logic signed [31:0] new_x,
    output logic signed [31:0] new_y,
    output logic               last
);
    import qvmr_pkg::*;

    logic      full;
    logic      push;
    cmd_t      front_cmd;
    logic      q_valid;
    logic      pop;
    cmd_t      head_cmd;
    logic      trig_start;
    trig_res_t trig_res;

    assign busy = full;

    // front: classify command words
    qvmr_front #(
        .VERTEX_COUNT(VERTEX_COUNT)
    ) u_front (
        .start(start),
        .full(full),
        .mode(mode),
        .vertex_sel(vertex_sel),
        .point_x(point_x),
        .point_y(point_y),
        .shift_x(shift_x),
        .shift_y(shift_y),
        .turn_angle(turn_angle),
        .push(push),
        .cmd(front_cmd)
    );

    // queue between front and back
    qvmr_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .cmd_in(front_cmd),
        .full(full),
        .pop(pop),
        .valid(q_valid),
        .cmd_out(head_cmd)
    );

    // sine and cosine unit
    qvmr_trig u_trig (
        .clk(clk),
        .rst_n(rst_n),
        .start(trig_start),
        .quad(head_cmd.quad),
        .rem(head_cmd.rem),
        .res(trig_res)
    );

    // back: store and sequencer
    qvmr_back #(
        .VERTEX_COUNT(VERTEX_COUNT),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_valid),
        .cmd(head_cmd),
        .pop(pop),
        .trig_start(trig_start),
        .trig(trig_res),
        .result_strobe(result_strobe),
        .vertex_index(vertex_index),
        .new_x(new_x),
        .new_y(new_y),
        .last(last)
    );

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench of quad_vertex_move_rotate_top (load, move, rotate)
// depends on qvmr_pkg and the rtl of quad_vertex_move_rotate_top; a local predictor
// works out every word, and a monitor checks each strobed word in order
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import qvmr_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam longint     COORD_MAX = 64'sd2147483647;
    localparam longint     COORD_MIN = -64'sd2147483648;
    localparam int         DEG360 = 92160;
    localparam int         DEG90 = 23040;

    typedef struct {
        logic [1:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               fin;
    } vertex_word_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         mode;
    logic [1:0]         vertex_sel;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [17:0] turn_angle;
    logic               result_strobe;
    logic [1:0]         vertex_index;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic               last;

    // shadow copy of the vertex store
    longint       shape_x [4];
    longint       shape_y [4];
    vertex_word_t pending_vertices [$];
    int           error_count;
    int           cycle_count;

    // arctangent table in Q2.30, truncated
    longint arctan_q30 [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
    };

    quad_vertex_move_rotate_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .vertex_sel    (vertex_sel),
        .point_x       (point_x),
        .point_y       (point_y),
        .shift_x       (shift_x),
        .shift_y       (shift_y),
        .turn_angle    (turn_angle),
        .result_strobe (result_strobe),
        .vertex_index  (vertex_index),
        .new_x         (new_x),
        .new_y         (new_y),
        .last          (last)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    // cos and sin in Q1.30 for an angle in 1/256 degree
    task automatic cos_sin_q30(input longint ang, output longint c, output longint s);
        longint a, q, r, x, y, z, xs, ys;
        a = ((ang % DEG360) + DEG360) % DEG360;
        q = a / DEG90;
        r = a % DEG90;
        x = 64'h26DD3B6A;
        y = 0;
        if (r == 0)
            x = 64'sd1073741824;
        else
        begin
            z = (r * 64'sd3373259426 + 23040) / 46080;
            for (int i = 0; i < 30; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys; y = y + xs; z = z - arctan_q30[i];
                end
                else
                begin
                    x = x + ys; y = y - xs; z = z + arctan_q30[i];
                end
            end
        end
        case (q)
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            3: begin c = y;  s = -x; end
            default: begin c = x; s = y; end
        endcase
    endtask

    // centre plus (p*c - m*s) / 2^31, rounded half up
    function automatic longint turned_coord(input longint p, input longint m, input longint c,
                                            input longint s, input longint sum2);
        logic signed [127:0] acc;
        acc = (128'(signed'(sum2)) <<< 30) + 128'(signed'(p)) * 128'(signed'(c))
              - 128'(signed'(m)) * 128'(signed'(s)) + (128'sd1 <<< 30);
        acc = acc >>> 31;
        return longint'(acc[63:0]);
    endfunction

    // predicted shape update and words for one accepted command
    task automatic predict_shape(input logic [1:0] md, input logic [1:0] sel,
                                 input logic signed [31:0] px, input logic signed [31:0] py,
                                 input logic signed [31:0] dx, input logic signed [31:0] dy,
                                 input logic signed [17:0] ang);
        longint c, s, sx, sy, d, e;
        vertex_word_t w;
        if (md == MODE_LOAD)
        begin
            shape_x[sel] = clamp_coord(longint'(px));
            shape_y[sel] = clamp_coord(longint'(py));
            return;
        end
        if (md == MODE_NONE)
            return;
        if (md == MODE_MOVE)
        begin
            for (int i = 0; i < 4; i++)
            begin
                shape_x[i] = clamp_coord(shape_x[i] + longint'(dx));
                shape_y[i] = clamp_coord(shape_y[i] + longint'(dy));
            end
        end
        else
        begin
            sx = shape_x[0] + shape_x[2];
            sy = shape_y[0] + shape_y[2];
            cos_sin_q30(longint'(ang), c, s);
            for (int i = 0; i < 4; i++)
            begin
                d = 2 * shape_x[i] - sx;
                e = 2 * shape_y[i] - sy;
                shape_x[i] = clamp_coord(turned_coord(d, e, c, s, sx));
                shape_y[i] = clamp_coord(turned_coord(e, -d, c, s, sy));
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            w.idx = 2'(i);
            w.x   = shape_x[i][31:0];
            w.y   = shape_y[i][31:0];
            w.fin = (i == 3);
            pending_vertices.push_back(w);
        end
    endtask

    // word checker
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (pending_vertices.size() == 0)
            begin
                $display("%0t: unexpected word idx=%0d x=%0d y=%0d last=%0b", $time,
                         vertex_index, new_x, new_y, last);
                error_count++;
            end
            else
            begin
                vertex_word_t w;
                w = pending_vertices.pop_front();
                if (vertex_index !== w.idx || new_x !== w.x || new_y !== w.y || last !== w.fin)
                begin
                    $display("%0t: mismatch expected idx=%0d x=%0d y=%0d last=%0b", $time,
                             w.idx, w.x, w.y, w.fin);
                    $display("%0t:          actual   idx=%0d x=%0d y=%0d last=%0b", $time,
                             vertex_index, new_x, new_y, last);
                    error_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[quad_vertex_move_rotate_top] ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 2) * $urandom_range(0, 1);
        return $urandom_range(8, 40);
    endfunction

    // send one word; entered and left at a falling edge
    task automatic send_word(input logic [1:0] md, input logic [1:0] sel,
                             input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [31:0] dx, input logic signed [31:0] dy,
                             input logic signed [17:0] ang, input int gap);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode = md; vertex_sel = sel; point_x = px; point_y = py;
        shift_x = dx; shift_y = dy; turn_angle = ang;
        start = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predict_shape(md, sel, px, py, dx, dy, ang);
        @(negedge clk);
    endtask

    task automatic load_vertex(input logic [1:0] sel, input logic signed [31:0] px,
                               input logic signed [31:0] py);
        send_word(MODE_LOAD, sel, px, py, $urandom, $urandom, 18'($urandom), pick_gap());
    endtask

    task automatic move_shape(input logic signed [31:0] dx, input logic signed [31:0] dy);
        send_word(MODE_MOVE, 2'($urandom), $urandom, $urandom, dx, dy, 18'($urandom),
                  pick_gap());
    endtask

    task automatic rotate_shape(input logic signed [17:0] ang);
        send_word(MODE_ROTATE, 2'($urandom), $urandom, $urandom, $urandom, $urandom, ang,
                  pick_gap());
    endtask

    // hold off until every expected word is back
    task automatic wait_drained();
        start = 1'b0;
        while (pending_vertices.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic signed [31:0] random_coord();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'sh7FFFFFFF - $urandom_range(0, 65536);
            2: return 32'sh80000000 + $urandom_range(0, 65536);
            default: return $signed(32'($urandom_range(0, 32'h01000000))) - 32'sh00800000;
        endcase
    endfunction

    // extremes of coordinates and saturation on move, then a quarter-turn rotate
    task automatic test_saturation();
        load_vertex(0, 32'sh7FFFFFFF, 32'sh80000000);
        load_vertex(1, 32'sh80000000, 32'sh7FFFFFFF);
        load_vertex(2, 0, 32'shFFFFFFFF);
        load_vertex(3, 32'sh00010000, -32'sh00010000);
        move_shape(32'sh7FFFFFFF, 32'sh80000000);
        move_shape(32'sh80000000, 32'sh7FFFFFFF);
        move_shape(0, 0);
        rotate_shape(18'sd23040);
    endtask

    // quadrant boundaries, wraparound and angle extremes, unused mode, then a small move
    task automatic test_angles();
        logic signed [17:0] angs [10] = '{18'sd0, 18'sd92160, -18'sd92160, 18'sd46080,
                                          18'sd69120, 18'sd1, -18'sd1, 18'sh1FFFF,
                                          18'sh20000, 18'sd11520};
        load_vertex(0, 32'sh00100000, 32'sh00050000);
        load_vertex(1, -32'sh00030000, 32'sh00200000);
        load_vertex(2, 32'sh00020001, -32'sh00070003);
        load_vertex(3, 32'sh7FFF0000, 32'sh80010000);
        foreach (angs[i])
            rotate_shape(angs[i]);
        send_word(MODE_NONE, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
                  18'($urandom), 0);
        move_shape(32'sh00000001, -32'sh00000001);
    endtask

    // random words: a mix of loads, moves, rotates and unused-mode words, rotates the most common
    task automatic test_random(input int n_words);
        int sent;
        sent = 0;
        while (sent < n_words)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    load_vertex(2'($urandom), random_coord(), random_coord());
                    sent++;
                end
                3, 4:
                begin
                    if ($urandom_range(0, 3) == 0)
                        move_shape($urandom, $urandom);
                    else
                        move_shape($signed(32'($urandom_range(0, 32'h00400000))) -
                                   32'sh00200000, $urandom_range(0, 32'h00400000));
                    sent++;
                end
                5:
                begin
                    send_word(MODE_NONE, 2'($urandom), $urandom, $urandom, $urandom,
                              $urandom, 18'($urandom), pick_gap());
                end
                default:
                begin
                    rotate_shape(18'($urandom));
                    sent++;
                end
            endcase
            if ($urandom_range(0, 40) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0; start = 1'b0; mode = MODE_LOAD; vertex_sel = 2'd0;
        point_x = '0; point_y = '0; shift_x = '0; shift_y = '0; turn_angle = '0;
        error_count = 0; cycle_count = 0;
        for (int i = 0; i < 4; i++)
        begin
            shape_x[i] = 0;
            shape_y[i] = 0;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // rotate of the cleared shape first
        rotate_shape(18'sd5000);
        test_saturation();
        wait_drained();
        test_angles();
        test_random(165);

        wait_drained();
        repeat (200) @(negedge clk);
        if (error_count == 0 && pending_vertices.size() == 0)
            $display("[quad_vertex_move_rotate_top] OK");
        else
            $display("[quad_vertex_move_rotate_top] ERROR");
        $finish;
    end

endmodule
